@@ src/pid_with_twiddle_tuning_unit_defines.svh @@
`ifndef PID_WITH_TWIDDLE_TUNING_UNIT_DEFINES_SVH
`define PID_WITH_TWIDDLE_TUNING_UNIT_DEFINES_SVH

// same-cycle implication
`define PTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ptt_pkg.sv @@
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int NUM_GAINS = 3;

  localparam logic [25:0]        STOP_THRESHOLD = 26'd131;
  localparam logic signed [26:0] GAIN_MAX       = 27'sd8388607;
  localparam logic signed [26:0] GAIN_MIN       = -27'sd8388608;
  localparam logic [16:0]        COUNT_MAX      = 17'h1ffff;
  localparam logic [15:0]        PERIOD_MAX     = 16'hffff;

  localparam logic [27:0] DELTA_UP_MUL   = 28'd11;
  localparam logic [27:0] DELTA_DOWN_MUL = 28'd9;
  localparam logic [27:0] DELTA_ROUND    = 28'd5;
  localparam logic [55:0] RECIP_TEN      = 56'd214748365;
  localparam int          RECIP_SHIFT    = 31;
  localparam int          QUOT_W         = 25;

  localparam logic signed [65:0] ONE_Q28    = 66'sd268435456;
  localparam logic signed [65:0] ROUND_HALF = 66'sd32768;
  localparam logic signed [13:0] CORR_ONE   = 14'sd4096;

  typedef enum logic [2:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_WARMUP,
    REG_PERIOD,
    REG_DP,
    REG_DI,
    REG_DD
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_PLUS,
    PH_MINUS,
    PH_RESTORE
  } phase_e;

  typedef logic signed [23:0] gain_t;
  typedef logic [23:0]        delta_t;

  localparam cfg_reg_e GAIN_REG[NUM_GAINS]  = '{REG_KP, REG_KI, REG_KD};
  localparam cfg_reg_e DELTA_REG[NUM_GAINS] = '{REG_DP, REG_DI, REG_DD};

  typedef struct packed {
    logic               valid;
    logic               retuned;
    logic               tuning_active;
    logic signed [15:0] prev;
    logic signed [39:0] integ;
    logic signed [16:0] deriv;
    gain_t              kp;
    gain_t              ki;
    gain_t              kd;
  } drive_t;

  function automatic gain_t sat_gain(input logic signed [26:0] v);
    gain_t r;
    if (v > GAIN_MAX) begin
      r = GAIN_MAX[23:0];
    end else if (v < GAIN_MIN) begin
      r = GAIN_MIN[23:0];
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

@@ src/ptt_delta_scale.sv @@
`timescale 1ns / 1ps

module ptt_delta_scale (
  input  ptt_pkg::delta_t delta_i,
  output ptt_pkg::delta_t up_o,
  output ptt_pkg::delta_t down_o
);
  import ptt_pkg::*;

  logic [27:0]       up_num;
  logic [27:0]       dn_num;
  logic [55:0]       up_prod;
  logic [55:0]       dn_prod;
  logic [QUOT_W-1:0] up_quot;
  logic [QUOT_W-1:0] dn_quot;

  assign up_num  = {4'b0, delta_i} * DELTA_UP_MUL + DELTA_ROUND;
  assign dn_num  = {4'b0, delta_i} * DELTA_DOWN_MUL + DELTA_ROUND;
  assign up_prod = {28'b0, up_num} * RECIP_TEN;
  assign dn_prod = {28'b0, dn_num} * RECIP_TEN;
  assign up_quot = up_prod[RECIP_SHIFT +: QUOT_W];
  assign dn_quot = dn_prod[RECIP_SHIFT +: QUOT_W];

  assign up_o   = up_quot[QUOT_W-1] ? '1 : up_quot[23:0];
  assign down_o = dn_quot[QUOT_W-1] ? '1 : dn_quot[23:0];

endmodule

@@ src/ptt_drive.sv @@
`timescale 1ns / 1ps

module ptt_drive (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  ptt_pkg::drive_t req_i,
  output logic            m_valid_o,
  output logic [15:0]     m_data_o,
  output logic [1:0]      m_user_o
);
  import ptt_pkg::*;

  logic signed [20:0] ilo;
  logic signed [19:0] ihi;
  logic signed [39:0] p0_w;
  logic signed [40:0] p2_w;
  logic signed [44:0] p1lo_w;
  logic signed [43:0] p1hi_w;
  logic signed [65:0] sum_w;
  logic signed [65:0] rnd_w;
  logic signed [13:0] corr_w;

  logic               vd_q;
  logic               retd_q;
  logic               tactd_q;
  logic signed [39:0] p0_q;
  logic signed [40:0] p2_q;
  logic signed [44:0] p1lo_q;
  logic signed [43:0] p1hi_q;

  logic               ve_q;
  logic               rete_q;
  logic               tacte_q;
  logic signed [65:0] sum_q;

  logic               mv_q;
  logic               ret_q;
  logic               tact_q;
  logic signed [13:0] corr_q;

  assign ilo    = {1'b0, req_i.integ[19:0]};
  assign ihi    = req_i.integ[39:20];
  assign p0_w   = req_i.kp * req_i.prev;
  assign p2_w   = req_i.kd * req_i.deriv;
  assign p1lo_w = req_i.ki * ilo;
  assign p1hi_w = req_i.ki * ihi;

  assign sum_w = 66'(p0_q) + 66'(p2_q) + 66'(p1lo_q) + (66'(p1hi_q) <<< 20);

  always_comb begin
    rnd_w = ROUND_HALF - sum_q;
    if (sum_q > ONE_Q28) begin
      corr_w = -CORR_ONE;
    end else if (sum_q < -ONE_Q28) begin
      corr_w = CORR_ONE;
    end else begin
      corr_w = rnd_w[29:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      mv_q <= 1'b0;
    end else if (adv_i) begin
      vd_q <= req_i.valid;
      ve_q <= vd_q;
      mv_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p0_q    <= p0_w;
      p2_q    <= p2_w;
      p1lo_q  <= p1lo_w;
      p1hi_q  <= p1hi_w;
      retd_q  <= req_i.retuned;
      tactd_q <= req_i.tuning_active;
      sum_q   <= sum_w;
      rete_q  <= retd_q;
      tacte_q <= tactd_q;
      corr_q  <= corr_w;
      ret_q   <= rete_q;
      tact_q  <= tacte_q;
    end
  end

  assign m_valid_o = mv_q;
  assign m_data_o  = {2'b00, corr_q};
  assign m_user_o  = {tact_q, ret_q};

endmodule

@@ src/pid_with_twiddle_tuning_unit.sv @@
`timescale 1ns / 1ps

// PID controller with twiddle gain tuning. Each error sample accepted on the
// slave stream yields one correction on the master stream, and a new sample
// can be taken every cycle unless the master stream stalls: the controller state
// (integral, squared-error sum, twiddle gains and deltas) closes its loop in a
// single registered update per sample, and the gain products and the clip run
// in a three-stage pipeline behind it. s_axis_tready is high whenever the
// output register is empty or being drained, so throughput follows
// m_axis_tready. Write the APB registers only while no sample is in flight.
// There is no clearing pass after reset.

module pid_with_twiddle_tuning_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata: [15:0] error_sample
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  // m_axis_tdata: [13:0] correction, [15:14] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  // m_axis_tuser: [0] retuned, [1] tuning_active
  output logic [1:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptt_pkg::*;
  `include "pid_with_twiddle_tuning_unit_defines.svh"

  logic     adv;
  logic     upd;
  logic     cfg_wr;
  cfg_reg_e cfg_idx;

  gain_t       ginit_q[NUM_GAINS];
  delta_t      dinit_q[NUM_GAINS];
  logic [15:0] warmup_q;
  logic [15:0] tperiod_q;

  logic               va_q;
  logic signed [15:0] ea_q;
  logic               vb_q;
  logic signed [15:0] eb_q;
  logic [30:0]        sqb_q;
  logic signed [31:0] sq_w;
  logic               vc_q;
  logic               retc_q;

  logic signed [15:0] prev_q,   prev_d;
  logic signed [39:0] integ_q,  integ_d;
  logic signed [16:0] deriv_q,  deriv_d;
  logic [16:0]        scount_q, scount_d;
  logic [15:0]        period_q, period_d;
  logic [47:0]        sqsum_q,  sqsum_d;
  logic [47:0]        best_q,   best_d;
  gain_t              wg_q[NUM_GAINS];
  gain_t              wg_d[NUM_GAINS];
  delta_t             wd_q[NUM_GAINS];
  delta_t             wd_d[NUM_GAINS];
  delta_t             up_q[NUM_GAINS];
  delta_t             dn_q[NUM_GAINS];
  logic [1:0]         gidx_q,   gidx_d;
  phase_e             phase_q,  phase_d;

  logic       sreq_v_q,     sreq_v_d;
  logic [1:0] sreq_idx_q,   sreq_idx_d;
  delta_t     sreq_delta_q, sreq_delta_d;
  delta_t     scale_up;
  delta_t     scale_dn;

  logic   g_hit[NUM_GAINS];
  logic   d_hit[NUM_GAINS];
  gain_t  g_src[NUM_GAINS];
  delta_t d_src[NUM_GAINS];
  delta_t ld_delta[NUM_GAINS];

  logic signed [16:0] deriv_n;
  logic signed [40:0] integ_w;
  logic signed [39:0] integ_n;
  logic [16:0]        scount_n;
  logic [48:0]        sq_add;
  logic [47:0]        sq_n;
  logic [16:0]        period_inc;
  logic               fire;
  logic [25:0]        dsum;
  logic               tun_on;
  logic               do_tw;
  logic               better;

  gain_t              tw_gain;
  delta_t             tw_d;
  logic signed [26:0] gplus;
  logic signed [26:0] gminus;
  gain_t              tw_gain_n;
  delta_t             tw_d_n;
  logic               tw_best;
  logic               tw_next;
  phase_e             tw_phase;

  drive_t      drv;
  logic        mv;
  logic [15:0] mdata;
  logic [1:0]  muser;

  assign adv           = !mv || m_axis_tready;
  assign s_axis_tready = adv;
  assign upd           = adv && vb_q;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign cfg_idx       = cfg_reg_e'(paddr[4:2]);
  assign pready        = 1'b1;
  assign sq_w          = ea_q * ea_q;

  always_comb begin
    case (cfg_idx)
      REG_KP:     prdata = {8'b0, ginit_q[0]};
      REG_KI:     prdata = {8'b0, ginit_q[1]};
      REG_KD:     prdata = {8'b0, ginit_q[2]};
      REG_WARMUP: prdata = {16'b0, warmup_q};
      REG_PERIOD: prdata = {16'b0, tperiod_q};
      REG_DP:     prdata = {8'b0, dinit_q[0]};
      REG_DI:     prdata = {8'b0, dinit_q[1]};
      REG_DD:     prdata = {8'b0, dinit_q[2]};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    for (int k = 0; k < NUM_GAINS; k++) begin
      g_hit[k]    = cfg_wr && (cfg_idx == GAIN_REG[k]);
      d_hit[k]    = cfg_wr && (cfg_idx == DELTA_REG[k]);
      g_src[k]    = g_hit[k] ? pwdata[23:0] : ginit_q[k];
      d_src[k]    = d_hit[k] ? pwdata[23:0] : dinit_q[k];
      ld_delta[k] = (g_src[k] == '0) ? '0 : d_src[k];
    end
  end

  always_comb begin
    deriv_n  = 17'(eb_q) - 17'(prev_q);
    integ_w  = 41'(integ_q) + 41'(eb_q);
    case (integ_w[40:39])
      2'b01:   integ_n = {1'b0, {39{1'b1}}};
      2'b10:   integ_n = {1'b1, {39{1'b0}}};
      default: integ_n = integ_w[39:0];
    endcase
    scount_n = (scount_q == COUNT_MAX) ? scount_q : scount_q + 17'd1;
    sq_add   = {1'b0, sqsum_q} + {18'b0, sqb_q};
    if (scount_n >= {1'b0, warmup_q}) begin
      sq_n = sq_add[48] ? '1 : sq_add[47:0];
    end else begin
      sq_n = sqsum_q;
    end
    period_inc = {1'b0, period_q} + 17'd1;
    fire       = (tperiod_q != '0) && (period_inc >= {1'b0, tperiod_q});
    dsum       = {2'b00, wd_q[0]} + {2'b00, wd_q[1]} + {2'b00, wd_q[2]};
    tun_on     = dsum > STOP_THRESHOLD;
    do_tw      = fire && tun_on;
    better     = sq_n < best_q;
  end

  always_comb begin
    tw_gain   = wg_q[gidx_q];
    tw_d      = wd_q[gidx_q];
    gplus     = 27'(tw_gain) + $signed({3'b000, tw_d});
    gminus    = 27'(tw_gain) - $signed({2'b00, tw_d, 1'b0});
    tw_gain_n = tw_gain;
    tw_d_n    = tw_d;
    tw_best   = 1'b0;
    tw_next   = 1'b0;
    tw_phase  = PH_PLUS;
    case (phase_q)
      PH_PLUS: begin
        tw_gain_n = sat_gain(gplus);
        tw_phase  = PH_MINUS;
      end
      PH_MINUS: begin
        if (better) begin
          tw_best = 1'b1;
          tw_d_n  = up_q[gidx_q];
          tw_next = 1'b1;
        end else begin
          tw_gain_n = sat_gain(gminus);
          tw_phase  = PH_RESTORE;
        end
      end
      PH_RESTORE: begin
        tw_next = 1'b1;
        if (better) begin
          tw_best = 1'b1;
          tw_d_n  = up_q[gidx_q];
        end else begin
          tw_gain_n = sat_gain(gplus);
          tw_d_n    = dn_q[gidx_q];
        end
      end
      default: begin
        tw_next = 1'b1;
      end
    endcase
  end

  always_comb begin
    prev_d       = prev_q;
    integ_d      = integ_q;
    deriv_d      = deriv_q;
    scount_d     = scount_q;
    period_d     = period_q;
    sqsum_d      = sqsum_q;
    best_d       = best_q;
    gidx_d       = gidx_q;
    phase_d      = phase_q;
    sreq_v_d     = 1'b0;
    sreq_idx_d   = sreq_idx_q;
    sreq_delta_d = sreq_delta_q;
    for (int k = 0; k < NUM_GAINS; k++) begin
      wg_d[k] = wg_q[k];
      wd_d[k] = wd_q[k];
    end
    if (cfg_wr) begin
      for (int k = 0; k < NUM_GAINS; k++) begin
        if (g_hit[k] || d_hit[k]) begin
          wg_d[k]      = g_src[k];
          wd_d[k]      = ld_delta[k];
          sreq_v_d     = 1'b1;
          sreq_idx_d   = 2'(k);
          sreq_delta_d = ld_delta[k];
        end
      end
    end else if (upd) begin
      scount_d = scount_n;
      if (fire) begin
        period_d = '0;
      end else if (period_q != PERIOD_MAX) begin
        period_d = period_inc[15:0];
      end
      if (do_tw) begin
        prev_d       = '0;
        integ_d      = '0;
        deriv_d      = '0;
        sqsum_d      = '0;
        best_d       = tw_best ? sq_n : best_q;
        wg_d[gidx_q] = tw_gain_n;
        wd_d[gidx_q] = tw_d_n;
        phase_d      = tw_phase;
        if (tw_next) begin
          gidx_d = (gidx_q == 2'(NUM_GAINS - 1)) ? '0 : gidx_q + 2'd1;
        end
        sreq_v_d     = 1'b1;
        sreq_idx_d   = gidx_q;
        sreq_delta_d = tw_d_n;
      end else begin
        prev_d  = eb_q;
        integ_d = integ_n;
        deriv_d = deriv_n;
        sqsum_d = sq_n;
      end
    end
  end

  ptt_delta_scale u_scale (
    .delta_i (sreq_delta_q),
    .up_o    (scale_up),
    .down_o  (scale_dn)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_GAINS; k++) begin
        ginit_q[k] <= '0;
        dinit_q[k] <= '0;
        wg_q[k]    <= '0;
        wd_q[k]    <= '0;
        up_q[k]    <= '0;
        dn_q[k]    <= '0;
      end
      warmup_q   <= '0;
      tperiod_q  <= '0;
      prev_q     <= '0;
      integ_q    <= '0;
      deriv_q    <= '0;
      scount_q   <= '0;
      period_q   <= '0;
      sqsum_q    <= '0;
      best_q     <= '1;
      gidx_q     <= '0;
      phase_q    <= PH_PLUS;
      sreq_v_q   <= 1'b0;
      sreq_idx_q <= '0;
      va_q       <= 1'b0;
      vb_q       <= 1'b0;
      vc_q       <= 1'b0;
    end else begin
      for (int k = 0; k < NUM_GAINS; k++) begin
        if (g_hit[k]) begin
          ginit_q[k] <= pwdata[23:0];
        end
        if (d_hit[k]) begin
          dinit_q[k] <= pwdata[23:0];
        end
        wg_q[k] <= wg_d[k];
        wd_q[k] <= wd_d[k];
        if (sreq_v_q && (sreq_idx_q == 2'(k))) begin
          up_q[k] <= scale_up;
          dn_q[k] <= scale_dn;
        end
      end
      if (cfg_wr && (cfg_idx == REG_WARMUP)) begin
        warmup_q <= pwdata[15:0];
      end
      if (cfg_wr && (cfg_idx == REG_PERIOD)) begin
        tperiod_q <= pwdata[15:0];
      end
      prev_q     <= prev_d;
      integ_q    <= integ_d;
      deriv_q    <= deriv_d;
      scount_q   <= scount_d;
      period_q   <= period_d;
      sqsum_q    <= sqsum_d;
      best_q     <= best_d;
      gidx_q     <= gidx_d;
      phase_q    <= phase_d;
      sreq_v_q   <= sreq_v_d;
      sreq_idx_q <= sreq_idx_d;
      if (adv) begin
        va_q <= s_axis_tvalid;
        vb_q <= va_q;
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sreq_delta_q <= sreq_delta_d;
    if (adv) begin
      ea_q   <= s_axis_tdata;
      eb_q   <= ea_q;
      sqb_q  <= sq_w[30:0];
      retc_q <= do_tw;
    end
  end

  // state registers already hold the post-update values of the sample in stage C
  assign drv = '{
    valid:         vc_q,
    retuned:       retc_q,
    tuning_active: tun_on,
    prev:          prev_q,
    integ:         integ_q,
    deriv:         deriv_q,
    kp:            wg_q[0],
    ki:            wg_q[1],
    kd:            wg_q[2]
  };

  ptt_drive u_drive (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .req_i     (drv),
    .m_valid_o (mv),
    .m_data_o  (mdata),
    .m_user_o  (muser)
  );

  assign m_axis_tvalid = mv;
  assign m_axis_tdata  = mdata;
  assign m_axis_tuser  = muser;

  `PTT_ASSERT_IMP(a_gidx_range, clk_i, rst_ni, 1'b1, gidx_q != 2'd3,
    "gain index out of range")
  `PTT_ASSERT_NXT(a_tw_clear, clk_i, rst_ni, upd && do_tw,
    prev_q == '0 && integ_q == '0 && sqsum_q == '0 && period_q == '0,
    "twiddle step did not clear the error terms")
  `PTT_ASSERT_NXT(a_best_mono, clk_i, rst_ni, 1'b1, best_q <= $past(best_q),
    "best error increased")
  `PTT_ASSERT_IMP(a_retune_zero, clk_i, rst_ni, mv && muser[0], mdata[13:0] == '0,
    "retuned request carries a nonzero correction")
  `PTT_ASSERT_IMP(a_corr_range, clk_i, rst_ni, mv,
    $signed(mdata[13:0]) <= CORR_ONE && $signed(mdata[13:0]) >= -CORR_ONE,
    "correction outside plus or minus one")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ptt_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int LONG_RUN = 20;
  localparam longint INTEG_HI = 64'sd549755813887;
  localparam longint INTEG_LO = -64'sd549755813888;
  localparam longint unsigned SQ_SAT = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [15:0] CORNER_ERRORS [12] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h1000,
    16'hF000, 16'h5555, 16'hAAAA, 16'h0800, 16'hFFF9, 16'h012C
  };

  typedef struct packed {
    logic [13:0] correction;
    logic        retuned;
    logic        tuning_active;
  } correction_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [15:0] error_samples [$];
  correction_t expected_corrections [$];
  int          sender_idle = 6;
  int          receiver_idle = 84;
  int          fails = 0;
  int          cycle_count = 0;
  bit          draining = 1'b0;
  logic [15:0] next_sample;
  correction_t want;

  // controller state
  logic signed [15:0] prev_err;
  longint             integ_acc;
  int                 deriv_val;
  int unsigned        sample_cnt;
  int unsigned        period_cnt;
  longint unsigned    sq_sum;
  longint unsigned    best_sq;
  gain_t              gain_w [3];
  delta_t             delta_w [3];
  int unsigned        tw_idx;
  phase_e             tw_phase;
  gain_t              gain_init [3];
  delta_t             delta_init [3];
  logic [15:0]        warmup_cfg;
  logic [15:0]        period_cfg;

  pid_with_twiddle_tuning_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic gain_t clip_gain(longint v);
    if (v > GAIN_MAX) begin
      return GAIN_MAX[23:0];
    end
    if (v < GAIN_MIN) begin
      return GAIN_MIN[23:0];
    end
    return v[23:0];
  endfunction

  function automatic delta_t scaled_delta(delta_t d, longint unsigned mul);
    longint unsigned r;
    r = (longint'(d) * mul + 5) / 10;
    return (r > 64'hFF_FFFF) ? 24'hFF_FFFF : r[23:0];
  endfunction

  function automatic bit deltas_above_stop();
    return (int'(delta_w[0]) + int'(delta_w[1]) + int'(delta_w[2])) > int'(STOP_THRESHOLD);
  endfunction

  function automatic void reload_gain(int k);
    gain_w[k]  = gain_init[k];
    delta_w[k] = (gain_init[k] == 0) ? '0 : delta_init[k];
  endfunction

  function automatic void reset_controller();
    prev_err   = '0;
    integ_acc  = 0;
    deriv_val  = 0;
    sample_cnt = 0;
    period_cnt = 0;
    sq_sum     = 0;
    best_sq    = SQ_SAT;
    tw_idx     = 0;
    tw_phase   = PH_PLUS;
    warmup_cfg = '0;
    period_cfg = '0;
    for (int k = 0; k < 3; k++) begin
      gain_init[k]  = '0;
      delta_init[k] = '0;
      reload_gain(k);
    end
  endfunction

  function automatic void apply_register(cfg_reg_e r, logic [31:0] v);
    case (r)
      REG_KP, REG_KI, REG_KD: begin
        gain_init[int'(r)] = v[23:0];
        reload_gain(int'(r));
      end
      REG_WARMUP: warmup_cfg = v[15:0];
      REG_PERIOD: period_cfg = v[15:0];
      default: begin
        delta_init[int'(r) - int'(REG_DP)] = v[23:0];
        reload_gain(int'(r) - int'(REG_DP));
      end
    endcase
  endfunction

  function automatic void twiddle_step();
    int unsigned g;
    longint      gain;
    delta_t      d;
    g    = (tw_idx > 2) ? 0 : tw_idx;
    gain = longint'(gain_w[g]);
    d    = delta_w[g];
    if (tw_phase == PH_PLUS) begin
      gain = gain + longint'(d);
    end else if (sq_sum < best_sq) begin
      best_sq  = sq_sum;
      d        = scaled_delta(d, DELTA_UP_MUL);
      tw_phase = PH_RESTORE;
    end else if (tw_phase == PH_MINUS) begin
      gain = gain - 2 * longint'(d);
    end else begin
      gain = gain + longint'(d);
      d    = scaled_delta(d, DELTA_DOWN_MUL);
    end
    gain_w[g]  = clip_gain(gain);
    delta_w[g] = d;
    sq_sum     = 0;
    prev_err   = '0;
    integ_acc  = 0;
    deriv_val  = 0;
    if (tw_phase == PH_RESTORE) begin
      tw_idx   = (g + 1) % 3;
      tw_phase = PH_PLUS;
    end else begin
      tw_idx   = g;
      tw_phase = (tw_phase == PH_PLUS) ? PH_MINUS : PH_RESTORE;
    end
  endfunction

  function automatic correction_t control_step(logic signed [15:0] e);
    correction_t     r;
    longint unsigned sq;
    longint          acc;
    longint          c;
    r.retuned = 1'b0;
    deriv_val = int'(e) - int'(prev_err);
    prev_err  = e;
    integ_acc = integ_acc + longint'(e);
    if (integ_acc > INTEG_HI) begin
      integ_acc = INTEG_HI;
    end
    if (integ_acc < INTEG_LO) begin
      integ_acc = INTEG_LO;
    end
    if (sample_cnt < COUNT_MAX) begin
      sample_cnt++;
    end
    if (sample_cnt >= warmup_cfg) begin
      sq     = longint'(e) * longint'(e);
      sq_sum = sq_sum + sq;
      if (sq_sum > SQ_SAT) begin
        sq_sum = SQ_SAT;
      end
    end
    if (period_cfg != 0 && period_cnt + 1 >= period_cfg) begin
      period_cnt = 0;
      if (deltas_above_stop()) begin
        twiddle_step();
        r.retuned = 1'b1;
      end
    end else if (period_cnt < PERIOD_MAX) begin
      period_cnt++;
    end
    acc = longint'(gain_w[0]) * longint'(prev_err) + longint'(gain_w[1]) * integ_acc
        + longint'(gain_w[2]) * longint'(deriv_val);
    acc = -acc;
    if (acc > ONE_Q28) begin
      c = 4096;
    end else if (acc < -ONE_Q28) begin
      c = -4096;
    end else begin
      c = (acc + ROUND_HALF) >>> 16;
    end
    r.correction    = c[13:0];
    r.tuning_active = deltas_above_stop();
    return r;
  endfunction

  function automatic logic [15:0] random_error();
    if ($urandom_range(3) == 0) begin
      return 16'($urandom);
    end
    return 16'(int'($urandom_range(8192)) - 4096);
  endfunction

  // sample driver: predict each request as it goes onto the bus
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (draining && expected_corrections.size() == 0) begin
        draining = 1'b0;
      end
      if (error_samples.size() != 0 && !draining && $urandom_range(99) >= sender_idle) begin
        next_sample = error_samples.pop_front();
        expected_corrections.push_back(control_step(next_sample));
        if ($urandom_range(63) == 0) begin
          draining = 1'b1;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_sample;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // correction monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_corrections.size() == 0) begin
          $display("%0t unexpected correction: expected none, actual 'h%h/%b", $time,
                   m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          want = expected_corrections.pop_front();
          if (m_axis_tdata !== {2'b00, want.correction}) begin
            $display("%0t correction: expected %0d, actual %0d (tdata 'h%h)", $time,
                     $signed(want.correction), $signed(m_axis_tdata[13:0]), m_axis_tdata);
            fails++;
          end
          if (m_axis_tuser[0] !== want.retuned) begin
            $display("%0t retuned: expected %b, actual %b", $time, want.retuned,
                     m_axis_tuser[0]);
            fails++;
          end
          if (m_axis_tuser[1] !== want.tuning_active) begin
            $display("%0t tuning_active: expected %b, actual %b", $time, want.tuning_active,
                     m_axis_tuser[1]);
            fails++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e r, logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_register(r, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (error_samples.size() != 0 || expected_corrections.size() != 0 || s_axis_tvalid);
  endtask

  task automatic push_random(int n);
    repeat (n) error_samples.push_back(random_error());
  endtask

  initial begin
    logic [31:0] kp_v, ki_v, kd_v, dp_v, di_v, dd_v;
    reset_controller();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one twiddle step, then full-scale negative samples with the tuning period at zero
    write_reg(REG_KP, 32'd65536);
    write_reg(REG_DP, 32'd6554);
    write_reg(REG_PERIOD, 32'd1);
    error_samples.push_back(16'd1000);
    wait_drained();
    write_reg(REG_PERIOD, 32'd0);
    repeat (LONG_RUN) error_samples.push_back(16'h8000);
    wait_drained();
    write_reg(REG_PERIOD, 32'd65535);
    push_random(3);
    wait_drained();

    sender_idle   = 6;
    receiver_idle = 84;
    write_reg(REG_KP, 32'd65536);
    write_reg(REG_KI, 32'(-300));
    write_reg(REG_KD, 32'd8388607);
    write_reg(REG_WARMUP, 32'd65535);
    write_reg(REG_PERIOD, 32'd4);
    write_reg(REG_DP, 32'd6554);
    write_reg(REG_DI, 32'd0);
    write_reg(REG_DD, 32'd16777215);
    foreach (CORNER_ERRORS[k]) error_samples.push_back(CORNER_ERRORS[k]);
    wait_drained();

    // shorten the period below the running count
    write_reg(REG_WARMUP, 32'd0);
    write_reg(REG_PERIOD, 32'd20);
    push_random(13);
    wait_drained();
    write_reg(REG_PERIOD, 32'd5);
    push_random(4);
    wait_drained();

    // zero integral gain, deltas just above the stop threshold
    write_reg(REG_KP, 32'd40000);
    write_reg(REG_KI, 32'd0);
    write_reg(REG_KD, 32'(-20000));
    write_reg(REG_DP, 32'd100);
    write_reg(REG_DI, 32'd5000);
    write_reg(REG_DD, 32'd40);
    write_reg(REG_PERIOD, 32'd2);
    push_random(12);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle   = 6;
          receiver_idle = 84;
        end
        1: begin
          sender_idle   = 84;
          receiver_idle = 6;
        end
        default: begin
          sender_idle   = 0;
          receiver_idle = 0;
        end
      endcase
      kp_v = 32'(int'($urandom_range(262144)) - 131072);
      ki_v = 32'(int'($urandom_range(16384)) - 8192);
      kd_v = 32'(int'($urandom_range(262144)) - 131072);
      dp_v = $urandom_range(65535);
      di_v = $urandom_range(65535);
      dd_v = $urandom_range(65535);
      if (ph == 0) begin
        kp_v = 32'd8388607;
        ki_v = 32'(-8388608);
        dp_v = 32'd16777215;
        di_v = 32'd16777215;
        dd_v = 32'd16777215;
      end else if (ph == 2) begin
        kp_v = 32'(-8388608);
        kd_v = 32'd8388607;
        dp_v = $urandom_range(16777215);
        dd_v = $urandom_range(16777215);
      end else if (ph == 3) begin
        dp_v = $urandom_range(300);
        di_v = $urandom_range(300);
        dd_v = $urandom_range(300);
      end
      write_reg(REG_KP, kp_v);
      write_reg(REG_KI, ki_v);
      write_reg(REG_KD, kd_v);
      write_reg(REG_WARMUP, $urandom_range(20));
      write_reg(REG_PERIOD, $urandom_range(1, 8));
      write_reg(REG_DP, dp_v);
      write_reg(REG_DI, di_v);
      write_reg(REG_DD, dd_v);
      push_random(85);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/ptt_pkg.sv
src/ptt_delta_scale.sv
src/ptt_drive.sv
src/pid_with_twiddle_tuning_unit.sv
sim/testbench.sv
